// ----- rtl/core/qau_pkg.sv -----
package qau_pkg;

  // Word format
  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 28;

  // Derived widths
  localparam int PROD_W   = 2 * WORD_BITS;
  localparam int HAM_W    = 2 * WORD_BITS + 2;
  localparam int N2_W     = 2 * WORD_BITS + 1;
  localparam int SQ_STEPS = (N2_W + 2 * FRAC_BITS + 1) / 2;
  localparam int SQ_XW    = 2 * SQ_STEPS;
  localparam int SQ_RW    = SQ_STEPS + 3;
  localparam int NUM_W    = (2 * WORD_BITS + 1 + FRAC_BITS > WORD_BITS + 2 * FRAC_BITS) ?
                            2 * WORD_BITS + 1 + FRAC_BITS : WORD_BITS + 2 * FRAC_BITS;
  localparam int DEN_W    = (N2_W > SQ_STEPS) ? N2_W : SQ_STEPS;
  localparam int QB       = WORD_BITS + 1;
  localparam int DIV_RW   = (NUM_W + 2 > DEN_W + 1 + QB) ? NUM_W + 2 : DEN_W + 1 + QB;

  // Saturation limits on the quotient magnitude
  localparam logic [QB-1:0] POS_LIM = QB'({(WORD_BITS - 1){1'b1}});
  localparam logic [QB-1:0] NEG_LIM = QB'(1) << (WORD_BITS - 1);

  // Operation codes
  localparam logic [2:0] KIND_ADD  = 3'd0;
  localparam logic [2:0] KIND_SUB  = 3'd1;
  localparam logic [2:0] KIND_MUL  = 3'd2;
  localparam logic [2:0] KIND_DIV  = 3'd3;
  localparam logic [2:0] KIND_NORM = 3'd4;
  localparam logic [2:0] KIND_INV  = 3'd5;

  // Hamilton product terms per lane (x, y, z, w): a index, b index, subtract
  localparam logic [1:0] HAM_A [4]    = '{2'd3, 2'd0, 2'd1, 2'd2};
  localparam logic [1:0] HAM_B [4][4] = '{'{2'd0, 2'd3, 2'd2, 2'd1},
                                          '{2'd1, 2'd2, 2'd3, 2'd0},
                                          '{2'd2, 2'd1, 2'd0, 2'd3},
                                          '{2'd3, 2'd0, 2'd1, 2'd2}};
  localparam logic [3:0] HAM_NEG [4]  = '{4'b1000, 4'b0010, 4'b0100, 4'b1110};
  localparam logic [1:0] SCALAR_IDX   = 2'd3;
  localparam logic [3:0] LANE_CONJ    = 4'b0111;

  typedef struct packed {
    logic [2:0]                  kind;
    logic signed [WORD_BITS-1:0] a_x;
    logic signed [WORD_BITS-1:0] a_y;
    logic signed [WORD_BITS-1:0] a_z;
    logic signed [WORD_BITS-1:0] a_w;
    logic signed [WORD_BITS-1:0] b_x;
    logic signed [WORD_BITS-1:0] b_y;
    logic signed [WORD_BITS-1:0] b_z;
    logic signed [WORD_BITS-1:0] b_w;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] r_x;
    logic signed [WORD_BITS-1:0] r_y;
    logic signed [WORD_BITS-1:0] r_z;
    logic signed [WORD_BITS-1:0] r_w;
    logic                        saturated;
    logic                        zero_divisor;
  } out_item_t;

  typedef struct packed {
    logic [N2_W-1:0] n2;
    logic            zdiv;
  } sq_tag_t;

  typedef struct packed {
    logic neg;
    logic zero;
    logic zdiv;
  } div_tag_t;

  typedef struct packed {
    logic [2:0]       kind;
    logic             neg;
    logic [NUM_W-1:0] mag;
  } lane_num_t;

  typedef struct packed {
    logic                        vld;
    logic signed [WORD_BITS-1:0] val;
    logic                        sat;
    logic                        zdiv;
  } lane_res_t;

endpackage

// ----- rtl/core/qau_sqrt.sv -----
module qau_sqrt (
  input  logic                           clk,
  input  qau_pkg::sq_tag_t               in_tag,
  output logic [qau_pkg::SQ_STEPS-1:0]   out_root,
  output qau_pkg::sq_tag_t               out_tag
);
  import qau_pkg::*;

  logic [SQ_RW-1:0]    rem_r  [SQ_STEPS];
  logic [SQ_STEPS-1:0] root_r [SQ_STEPS];
  sq_tag_t             tag_r  [SQ_STEPS];

  logic [SQ_RW-1:0]    rem_p  [SQ_STEPS];
  logic [SQ_STEPS-1:0] root_p [SQ_STEPS];
  sq_tag_t             tag_p  [SQ_STEPS];
  logic [SQ_RW-1:0]    rem_nxt  [SQ_STEPS];
  logic [SQ_STEPS-1:0] root_nxt [SQ_STEPS];

  // Select each stage's incoming remainder, root and tag
  always_comb begin
    rem_p[0]  = '0;
    root_p[0] = '0;
    tag_p[0]  = in_tag;
    for (int k = 1; k < SQ_STEPS; k++) begin
      rem_p[k]  = rem_r[k-1];
      root_p[k] = root_r[k-1];
      tag_p[k]  = tag_r[k-1];
    end
  end

  // One root bit per stage: bring down two radicand bits, trial subtract
  always_comb begin
    logic [SQ_XW-1:0] x;
    logic [SQ_RW-1:0] rem_sh;
    logic [SQ_RW-1:0] trial;
    logic             ge;
    for (int k = 0; k < SQ_STEPS; k++) begin
      x           = SQ_XW'(tag_p[k].n2) << (2 * FRAC_BITS);
      rem_sh      = (rem_p[k] << 2) | SQ_RW'(x[SQ_XW-1-2*k -: 2]);
      trial       = (SQ_RW'(root_p[k]) << 2) | SQ_RW'(1);
      ge          = rem_sh >= trial;
      rem_nxt[k]  = ge ? rem_sh - trial : rem_sh;
      root_nxt[k] = {root_p[k][SQ_STEPS-2:0], ge};
    end
  end

  // Advance the stages
  always_ff @(posedge clk) begin
    for (int k = 0; k < SQ_STEPS; k++) begin
      rem_r[k]  <= rem_nxt[k];
      root_r[k] <= root_nxt[k];
      tag_r[k]  <= tag_p[k];
    end
  end

  assign out_root = root_r[SQ_STEPS-1];
  assign out_tag  = tag_r[SQ_STEPS-1];

endmodule

// ----- rtl/core/qau_div.sv -----
module qau_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_vld,
  input  qau_pkg::div_tag_t            in_tag,
  input  logic [qau_pkg::NUM_W-1:0]    in_mag,
  input  logic [qau_pkg::DEN_W-1:0]    in_den,
  output logic                         out_vld,
  output qau_pkg::div_tag_t            out_tag,
  output logic [qau_pkg::QB-1:0]       out_q,
  output logic                         out_ovf
);
  import qau_pkg::*;

  logic [DIV_RW-1:0] nn;
  logic [DIV_RW-1:0] dd;
  logic              ovf_nxt;

  logic [DIV_RW-1:0] rem_r [QB+1];
  logic [DIV_RW-1:0] dd_r  [QB+1];
  logic [QB-1:0]     q_r   [QB+1];
  logic              ovf_r [QB+1];
  div_tag_t          tag_r [QB+1];
  logic [QB:0]       vld_r;

  logic [DIV_RW-1:0] rem_nxt [1:QB];
  logic [QB-1:0]     q_nxt   [1:QB];

  // Round half away: floor((2m + d) / 2d); flag quotients past the kept bits
  assign nn      = (DIV_RW'(in_mag) << 1) + DIV_RW'(in_den);
  assign dd      = DIV_RW'(in_den) << 1;
  assign ovf_nxt = nn >= (dd << QB);

  // One quotient bit per stage, most significant first
  always_comb begin
    logic [DIV_RW-1:0] trial;
    logic              ge;
    for (int k = 1; k <= QB; k++) begin
      trial      = dd_r[k-1] << (QB - k);
      ge         = rem_r[k-1] >= trial;
      rem_nxt[k] = ge ? rem_r[k-1] - trial : rem_r[k-1];
      q_nxt[k]   = q_r[k-1] | (QB'(ge) << (QB - k));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[QB-1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0] <= nn;
    dd_r[0]  <= dd;
    q_r[0]   <= '0;
    ovf_r[0] <= ovf_nxt;
    tag_r[0] <= in_tag;
    for (int k = 1; k <= QB; k++) begin
      rem_r[k] <= rem_nxt[k];
      dd_r[k]  <= dd_r[k-1];
      q_r[k]   <= q_nxt[k];
      ovf_r[k] <= ovf_r[k-1];
      tag_r[k] <= tag_r[k-1];
    end
  end

  assign out_vld = vld_r[QB];
  assign out_tag = tag_r[QB];
  assign out_q   = q_r[QB];
  assign out_ovf = ovf_r[QB];

endmodule

// ----- rtl/core/qau_lane.sv -----
module qau_lane (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_vld,
  input  logic [2:0]                            in_kind,
  input  logic signed [qau_pkg::WORD_BITS-1:0]  in_ta [4],
  input  logic signed [qau_pkg::WORD_BITS-1:0]  in_tb [4],
  input  logic [3:0]                            in_tneg,
  input  logic signed [qau_pkg::WORD_BITS-1:0]  own_a,
  input  logic signed [qau_pkg::WORD_BITS-1:0]  own_b,
  input  logic                                  conj,
  input  logic [qau_pkg::DEN_W-1:0]             den_n2,
  input  logic [qau_pkg::DEN_W-1:0]             den_root,
  input  logic                                  zdiv,
  output qau_pkg::lane_res_t                    res
);
  import qau_pkg::*;

  // Stage 1: term products
  logic signed [PROD_W-1:0]    prod_r [4];
  logic [3:0]                  neg1_r;
  logic [2:0]                  kind1_r;
  logic signed [WORD_BITS-1:0] a1_r;
  logic signed [WORD_BITS-1:0] b1_r;
  logic                        conj1_r;
  logic                        vld1_r;

  // Stage 2: term sum and elementwise sum
  logic signed [HAM_W-1:0]     ham_nxt;
  logic signed [HAM_W-1:0]     ham_r;
  logic signed [WORD_BITS:0]   as_nxt;
  logic signed [WORD_BITS:0]   as_r;
  logic [2:0]                  kind2_r;
  logic signed [WORD_BITS-1:0] a2_r;
  logic                        conj2_r;
  logic                        vld2_r;

  // Stage 3 and alignment delay
  logic [HAM_W-1:0]            hmag;
  logic [HAM_W-1:0]            hrnd;
  logic [WORD_BITS:0]          amag;
  logic [WORD_BITS:0]          asmag;
  lane_num_t                   num_nxt;
  lane_num_t                   dly_r [SQ_STEPS];
  logic [SQ_STEPS-1:0]         dvld_r;

  // Divider hookup and final saturation
  lane_num_t                   cur;
  logic [DEN_W-1:0]            den_sel;
  div_tag_t                    dtag_in;
  logic                        d_vld;
  div_tag_t                    d_tag;
  logic [QB-1:0]               d_q;
  logic                        d_ovf;
  logic [QB-1:0]               d_qn;
  logic signed [WORD_BITS-1:0] val_nxt;
  logic                        sat_nxt;
  logic signed [WORD_BITS-1:0] val_r;
  logic                        sat_r;
  logic                        zdiv_r;
  logic                        vld_r;

  always_ff @(posedge clk) begin
    for (int j = 0; j < 4; j++) begin
      prod_r[j] <= PROD_W'(in_ta[j]) * PROD_W'(in_tb[j]);
    end
    neg1_r  <= in_tneg;
    kind1_r <= in_kind;
    a1_r    <= own_a;
    b1_r    <= own_b;
    conj1_r <= conj;
  end

  // Sum signed terms; add or subtract own components
  always_comb begin
    ham_nxt = '0;
    for (int j = 0; j < 4; j++) begin
      if (neg1_r[j]) begin
        ham_nxt = ham_nxt - HAM_W'(prod_r[j]);
      end else begin
        ham_nxt = ham_nxt + HAM_W'(prod_r[j]);
      end
    end
    if (kind1_r == KIND_SUB) begin
      as_nxt = (WORD_BITS+1)'(a1_r) - (WORD_BITS+1)'(b1_r);
    end else begin
      as_nxt = (WORD_BITS+1)'(a1_r) + (WORD_BITS+1)'(b1_r);
    end
  end

  always_ff @(posedge clk) begin
    ham_r   <= ham_nxt;
    as_r    <= as_nxt;
    kind2_r <= kind1_r;
    a2_r    <= a1_r;
    conj2_r <= conj1_r;
  end

  // Split into sign and magnitude numerator
  always_comb begin
    hmag  = ham_r[HAM_W-1] ? HAM_W'(-ham_r) : HAM_W'(ham_r);
    hrnd  = hmag + (HAM_W'(1) << (FRAC_BITS - 1));
    amag  = a2_r[WORD_BITS-1] ? -(WORD_BITS+1)'(a2_r) : (WORD_BITS+1)'(a2_r);
    asmag = as_r[WORD_BITS] ? (WORD_BITS+1)'(-as_r) : (WORD_BITS+1)'(as_r);
    num_nxt.kind = kind2_r;
    unique case (kind2_r)
      KIND_ADD, KIND_SUB: begin
        num_nxt.neg = as_r[WORD_BITS];
        num_nxt.mag = NUM_W'(asmag);
      end
      KIND_MUL: begin
        num_nxt.neg = ham_r[HAM_W-1];
        num_nxt.mag = NUM_W'(hrnd >> FRAC_BITS);
      end
      KIND_DIV: begin
        num_nxt.neg = ham_r[HAM_W-1];
        num_nxt.mag = NUM_W'(hmag) << FRAC_BITS;
      end
      KIND_NORM: begin
        num_nxt.neg = a2_r[WORD_BITS-1];
        num_nxt.mag = NUM_W'(amag) << (2 * FRAC_BITS);
      end
      KIND_INV: begin
        num_nxt.neg = conj2_r ? ((a2_r != '0) && !a2_r[WORD_BITS-1]) : a2_r[WORD_BITS-1];
        num_nxt.mag = NUM_W'(amag) << (2 * FRAC_BITS);
      end
      default: begin
        num_nxt.neg = 1'b0;
        num_nxt.mag = '0;
      end
    endcase
  end

  // Hold the numerator until the shared divisor arrives
  always_ff @(posedge clk) begin
    dly_r[0] <= num_nxt;
    for (int k = 1; k < SQ_STEPS; k++) begin
      dly_r[k] <= dly_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      dvld_r <= '0;
      vld_r  <= 1'b0;
    end else begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
      dvld_r <= {dvld_r[SQ_STEPS-2:0], vld2_r};
      vld_r  <= d_vld;
    end
  end

  // Pick the divisor; a divisor of one passes the magnitude through
  assign cur = dly_r[SQ_STEPS-1];
  always_comb begin
    unique case (cur.kind)
      KIND_DIV, KIND_INV: den_sel = den_n2;
      KIND_NORM:          den_sel = den_root;
      default:            den_sel = DEN_W'(1);
    endcase
    dtag_in.neg  = cur.neg;
    dtag_in.zdiv = zdiv;
    dtag_in.zero = zdiv || (cur.kind != KIND_ADD && cur.kind != KIND_SUB &&
                            cur.kind != KIND_MUL && cur.kind != KIND_DIV &&
                            cur.kind != KIND_NORM && cur.kind != KIND_INV);
  end

  qau_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (dvld_r[SQ_STEPS-1]),
    .in_tag  (dtag_in),
    .in_mag  (cur.mag),
    .in_den  (den_sel),
    .out_vld (d_vld),
    .out_tag (d_tag),
    .out_q   (d_q),
    .out_ovf (d_ovf)
  );

  // Apply sign and clip to the word range
  assign d_qn = ~d_q + QB'(1);
  always_comb begin
    if (d_tag.zero) begin
      val_nxt = '0;
      sat_nxt = 1'b0;
    end else if (!d_tag.neg) begin
      if (d_ovf || d_q > POS_LIM) begin
        val_nxt = {1'b0, {(WORD_BITS - 1){1'b1}}};
        sat_nxt = 1'b1;
      end else begin
        val_nxt = d_q[WORD_BITS-1:0];
        sat_nxt = 1'b0;
      end
    end else if (d_ovf || d_q > NEG_LIM) begin
      val_nxt = {1'b1, {(WORD_BITS - 1){1'b0}}};
      sat_nxt = 1'b1;
    end else begin
      val_nxt = d_qn[WORD_BITS-1:0];
      sat_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    val_r  <= val_nxt;
    sat_r  <= sat_nxt;
    zdiv_r <= d_tag.zdiv;
  end

  assign res.vld  = vld_r;
  assign res.val  = val_r;
  assign res.sat  = sat_r;
  assign res.zdiv = zdiv_r;

endmodule

// ----- rtl/core/quaternion_arith_unit_top.sv -----
// Channel  | Ports                    | Handshake
// ---------+--------------------------+---------------------------------------
// input    | start, busy, in_item     | beat taken when start high, busy low
// result   | out_strobe, out_item     | beat valid for one cycle on out_strobe
//
// One item is taken every cycle; busy stays low.
// Every item passes through the pipelined square root (one root bit per
// stage) and the per-lane restoring divider (one quotient bit per stage).
// Reset clears only the valid chain; results in flight are dropped.
// The receiver cannot stall; results are never held.
module quaternion_arith_unit_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  qau_pkg::in_item_t  in_item,
  output logic               out_strobe,
  output qau_pkg::out_item_t out_item
);
  import qau_pkg::*;

  in_item_t                    in_r;
  logic                        in_vld_r;
  logic signed [WORD_BITS-1:0] qa [4];
  logic signed [WORD_BITS-1:0] qb [4];
  logic signed [WORD_BITS-1:0] nq [4];

  logic signed [WORD_BITS-1:0] lane_ta   [4][4];
  logic signed [WORD_BITS-1:0] lane_tb   [4][4];
  logic [3:0]                  lane_tneg [4];
  lane_res_t                   lane_res  [4];

  logic signed [PROD_W-1:0]    nsq_r [4];
  logic [2:0]                  kind1_r;
  logic [N2_W-1:0]             n2_nxt;
  logic [N2_W-1:0]             n2_r;
  logic                        zdiv_r;
  sq_tag_t                     sq_in;
  sq_tag_t                     sq_out;
  logic [SQ_STEPS-1:0]         root;

  logic                        out_strobe_r;
  out_item_t                   out_item_r;

  assign busy = 1'b0;

  // Capture the beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    in_r <= in_item;
  end

  assign qa = '{in_r.a_x, in_r.a_y, in_r.a_z, in_r.a_w};
  assign qb = '{in_r.b_x, in_r.b_y, in_r.b_z, in_r.b_w};

  // Route Hamilton terms to lanes; divide uses the conjugate of b
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      for (int j = 0; j < 4; j++) begin
        lane_ta[l][j]      = qa[HAM_A[j]];
        lane_tb[l][j]      = qb[HAM_B[l][j]];
        lane_tneg[l][j]    = HAM_NEG[l][j] ^
                             ((in_r.kind == KIND_DIV) && (HAM_B[l][j] != SCALAR_IDX));
      end
    end
  end

  // Squared norm of the divisor quaternion
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      nq[i] = (in_r.kind == KIND_DIV) ? qb[i] : qa[i];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      nsq_r[i] <= PROD_W'(nq[i]) * PROD_W'(nq[i]);
    end
    kind1_r <= in_r.kind;
  end

  always_comb begin
    n2_nxt = '0;
    for (int i = 0; i < 4; i++) begin
      n2_nxt = n2_nxt + N2_W'(unsigned'(nsq_r[i]));
    end
  end

  always_ff @(posedge clk) begin
    n2_r   <= n2_nxt;
    zdiv_r <= (n2_nxt == '0) &&
              (kind1_r == KIND_DIV || kind1_r == KIND_NORM || kind1_r == KIND_INV);
  end

  assign sq_in.n2   = n2_r;
  assign sq_in.zdiv = zdiv_r;

  qau_sqrt u_sqrt (
    .clk      (clk),
    .in_tag   (sq_in),
    .out_root (root),
    .out_tag  (sq_out)
  );

  for (genvar l = 0; l < 4; l++) begin : g_lane
    qau_lane u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_vld   (in_vld_r),
      .in_kind  (in_r.kind),
      .in_ta    (lane_ta[l]),
      .in_tb    (lane_tb[l]),
      .in_tneg  (lane_tneg[l]),
      .own_a    (qa[l]),
      .own_b    (qb[l]),
      .conj     (LANE_CONJ[l]),
      .den_n2   (DEN_W'(sq_out.n2)),
      .den_root (DEN_W'(root)),
      .zdiv     (sq_out.zdiv),
      .res      (lane_res[l])
    );
  end

  // Merge lanes into one result beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= lane_res[0].vld;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r.r_x          <= lane_res[0].val;
    out_item_r.r_y          <= lane_res[1].val;
    out_item_r.r_z          <= lane_res[2].val;
    out_item_r.r_w          <= lane_res[3].val;
    out_item_r.saturated    <= lane_res[0].sat | lane_res[1].sat |
                               lane_res[2].sat | lane_res[3].sat;
    out_item_r.zero_divisor <= lane_res[0].zdiv;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    (lane_res[0].vld == lane_res[1].vld) && (lane_res[0].vld == lane_res[2].vld) &&
    (lane_res[0].vld == lane_res[3].vld))
    else $error("lane valids diverged");

  a_merge_follows: assert property (@(posedge clk) disable iff (!rst_n)
    lane_res[0].vld |=> out_strobe)
    else $error("lane result not merged");

  a_zdiv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.zero_divisor) |->
      (out_item.r_x == '0) && (out_item.r_y == '0) &&
      (out_item.r_z == '0) && (out_item.r_w == '0))
    else $error("zero divisor with nonzero result");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !(out_item.saturated && out_item.zero_divisor))
    else $error("saturated together with zero divisor");

endmodule

// ----- test/quaternion_arith_unit_checker.sv -----
module quaternion_arith_unit_checker
  import qau_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  in_item_t  in_item,
  input  logic      out_strobe,
  input  out_item_t out_item,
  output int        mismatch_count,
  output int        pending_count
);

  typedef logic signed [255:0] wide_t;
  typedef logic [255:0] uwide_t;

  out_item_t quat_results_q[$];

  initial mismatch_count = 0;
  assign pending_count = quat_results_q.size();

  function automatic wide_t mag(wide_t v);
    return (v < 0) ? -v : v;
  endfunction

  // Divide by a positive divisor, rounding half away from zero
  function automatic wide_t round_div(wide_t num, wide_t den);
    wide_t q;
    q = ((mag(num) <<< 1) + den) / (den <<< 1);
    return (num < 0) ? -q : q;
  endfunction

  // Drop the fraction bits of a product, rounding half away from zero
  function automatic wide_t round_shift(wide_t v);
    wide_t m;
    m = (mag(v) + (wide_t'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    return (v < 0) ? -m : m;
  endfunction

  // Integer square root, floor
  function automatic wide_t isqrt(uwide_t x);
    uwide_t res, bit_v, t;
    res = '0;
    bit_v = uwide_t'(1) << 254;
    while (bit_v != 0 && bit_v > x) bit_v = bit_v >> 2;
    while (bit_v != 0) begin
      t = res + bit_v;
      if (x >= t) begin
        x = x - t;
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return wide_t'(res);
  endfunction

  // Components are ordered x, y, z, w
  function automatic void hamilton(input wide_t a[4], input wide_t b[4], output wide_t p[4]);
    p[0] = a[3]*b[0] + a[0]*b[3] + a[1]*b[2] - a[2]*b[1];
    p[1] = a[3]*b[1] - a[0]*b[2] + a[1]*b[3] + a[2]*b[0];
    p[2] = a[3]*b[2] + a[0]*b[1] - a[1]*b[0] + a[2]*b[3];
    p[3] = a[3]*b[3] - a[0]*b[0] - a[1]*b[1] - a[2]*b[2];
  endfunction

  function automatic out_item_t predict_quat(in_item_t it);
    wide_t a[4], b[4], r[4], t[4], cj[4];
    wide_t n2, den, hi, lo;
    logic sat, zdiv;
    logic [WORD_BITS-1:0] w[4];
    out_item_t res;
    a[0] = it.a_x; a[1] = it.a_y; a[2] = it.a_z; a[3] = it.a_w;
    b[0] = it.b_x; b[1] = it.b_y; b[2] = it.b_z; b[3] = it.b_w;
    for (int i = 0; i < 4; i++) r[i] = 0;
    sat = 1'b0;
    zdiv = 1'b0;
    case (it.kind)
      KIND_ADD: for (int i = 0; i < 4; i++) r[i] = a[i] + b[i];
      KIND_SUB: for (int i = 0; i < 4; i++) r[i] = a[i] - b[i];
      KIND_MUL: begin
        hamilton(a, b, t);
        for (int i = 0; i < 4; i++) r[i] = round_shift(t[i]);
      end
      KIND_DIV: begin
        n2 = b[0]*b[0] + b[1]*b[1] + b[2]*b[2] + b[3]*b[3];
        if (n2 == 0) begin
          zdiv = 1'b1;
        end else begin
          cj[0] = -b[0]; cj[1] = -b[1]; cj[2] = -b[2]; cj[3] = b[3];
          hamilton(a, cj, t);
          for (int i = 0; i < 4; i++) r[i] = round_div(t[i] <<< FRAC_BITS, n2);
        end
      end
      KIND_NORM: begin
        n2 = a[0]*a[0] + a[1]*a[1] + a[2]*a[2] + a[3]*a[3];
        if (n2 == 0) begin
          zdiv = 1'b1;
        end else begin
          den = isqrt(uwide_t'(n2 <<< (2 * FRAC_BITS)));
          for (int i = 0; i < 4; i++) r[i] = round_div(a[i] <<< (2 * FRAC_BITS), den);
        end
      end
      KIND_INV: begin
        n2 = a[0]*a[0] + a[1]*a[1] + a[2]*a[2] + a[3]*a[3];
        if (n2 == 0) begin
          zdiv = 1'b1;
        end else begin
          cj[0] = -a[0]; cj[1] = -a[1]; cj[2] = -a[2]; cj[3] = a[3];
          for (int i = 0; i < 4; i++) r[i] = round_div(cj[i] <<< (2 * FRAC_BITS), n2);
        end
      end
      default: ;
    endcase
    // Clip each component to the word range
    hi = (wide_t'(1) <<< (WORD_BITS - 1)) - 1;
    lo = -(wide_t'(1) <<< (WORD_BITS - 1));
    for (int i = 0; i < 4; i++) begin
      if (r[i] > hi) begin
        r[i] = hi;
        sat = 1'b1;
      end else if (r[i] < lo) begin
        r[i] = lo;
        sat = 1'b1;
      end
      w[i] = r[i][WORD_BITS-1:0];
    end
    res.r_x = w[0];
    res.r_y = w[1];
    res.r_z = w[2];
    res.r_w = w[3];
    res.saturated = sat;
    res.zero_divisor = zdiv;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [WORD_BITS-1:0] got,
                                 logic [WORD_BITS-1:0] want);
    $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Record expectations for input beats, compare result beats
  always @(posedge clk) begin
    out_item_t exp_item;
    if (rst_n) begin
      if (start && !busy) quat_results_q.push_back(predict_quat(in_item));
      if (out_strobe) begin
        if (quat_results_q.size() == 0) begin
          report_mismatch("unexpected result", out_item.r_x, '0);
        end else begin
          exp_item = quat_results_q.pop_front();
          if (out_item.r_x !== exp_item.r_x) report_mismatch("r_x", out_item.r_x, exp_item.r_x);
          if (out_item.r_y !== exp_item.r_y) report_mismatch("r_y", out_item.r_y, exp_item.r_y);
          if (out_item.r_z !== exp_item.r_z) report_mismatch("r_z", out_item.r_z, exp_item.r_z);
          if (out_item.r_w !== exp_item.r_w) report_mismatch("r_w", out_item.r_w, exp_item.r_w);
          if (out_item.saturated !== exp_item.saturated)
            report_mismatch("saturated", WORD_BITS'(out_item.saturated),
                            WORD_BITS'(exp_item.saturated));
          if (out_item.zero_divisor !== exp_item.zero_divisor)
            report_mismatch("zero_divisor", WORD_BITS'(out_item.zero_divisor),
                            WORD_BITS'(exp_item.zero_divisor));
        end
      end
    end
  end

endmodule

// ----- test/quaternion_arith_unit_top_tb.sv -----
module quaternion_arith_unit_top_tb;
  import qau_pkg::*;

  localparam int RANDOM_ITEMS = 1600;
  localparam int DRAIN_CYCLES = 120;
  localparam int IDLE_LIMIT   = 2000;
  localparam logic signed [WORD_BITS-1:0] ONE  = 1 <<< FRAC_BITS;
  localparam logic signed [WORD_BITS-1:0] WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [WORD_BITS-1:0] WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_strobe;
  out_item_t out_item;
  int        mismatch_count;
  int        pending_count;
  int        idle_cycles;
  int        burst_left;

  quaternion_arith_unit_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  quaternion_arith_unit_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_item        (in_item),
    .out_strobe     (out_strobe),
    .out_item       (out_item),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: end the run when no beat moves for too long
  initial idle_cycles = 0;
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Pick a component: full range, near unit scale, small integers, zero or an extreme
  function automatic logic signed [WORD_BITS-1:0] rand_comp();
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom;
      3, 4, 5: return $signed($urandom_range(0, 2 * ONE)) - ONE;
      6:       return $signed($urandom_range(0, 4096)) - 2048;
      7:       return '0;
      8:       return ($urandom_range(0, 1)) ? WMAX : WMIN;
      default: return $signed($urandom_range(0, 6 * ONE)) - 3 * ONE;
    endcase
  endfunction

  // Send one beat; bursts keep start high, gaps lower it
  task automatic send_beat(in_item_t it);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
    end
    burst_left--;
    start <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic send_quat(logic [2:0] kind, logic signed [WORD_BITS-1:0] ax,
                           logic signed [WORD_BITS-1:0] ay, logic signed [WORD_BITS-1:0] az,
                           logic signed [WORD_BITS-1:0] aw, logic signed [WORD_BITS-1:0] bx,
                           logic signed [WORD_BITS-1:0] by, logic signed [WORD_BITS-1:0] bz,
                           logic signed [WORD_BITS-1:0] bw);
    in_item_t it;
    it.kind = kind;
    it.a_x = ax; it.a_y = ay; it.a_z = az; it.a_w = aw;
    it.b_x = bx; it.b_y = by; it.b_z = bz; it.b_w = bw;
    send_beat(it);
  endtask

  initial begin
    in_item_t it;
    int wait_cycles;
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    burst_left = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, every kind, zero divisors, unused kinds
    send_quat(KIND_ADD, WMAX, WMIN, WMAX, WMIN, WMAX, WMIN, 0, 1);
    send_quat(KIND_SUB, WMAX, WMIN, 0, -1, WMIN, WMAX, 1, WMAX);
    send_quat(KIND_ADD, ONE, -ONE, 3, -3, -ONE, ONE, -3, 3);
    send_quat(KIND_MUL, ONE, 0, 0, 0, 0, ONE, 0, 0);
    send_quat(KIND_MUL, WMAX, WMAX, WMIN, WMIN, WMAX, WMIN, WMAX, WMIN);
    send_quat(KIND_MUL, 1, 1, 1, 1, -1, 1, -1, 1);
    send_quat(KIND_DIV, ONE, ONE, 0, 0, 0, 0, 0, ONE);
    send_quat(KIND_DIV, ONE, 2, 3, 4, 0, 0, 0, 0);
    send_quat(KIND_DIV, WMAX, WMIN, WMAX, WMIN, 0, 0, 1, 0);
    send_quat(KIND_DIV, WMIN, WMIN, WMIN, WMIN, WMIN, WMIN, WMIN, WMIN);
    send_quat(KIND_NORM, ONE, ONE, ONE, ONE, 0, 0, 0, 0);
    send_quat(KIND_NORM, 0, 0, 0, 0, ONE, ONE, ONE, ONE);
    send_quat(KIND_NORM, 1, 0, 0, 0, 0, 0, 0, 0);
    send_quat(KIND_NORM, WMIN, WMIN, WMIN, WMIN, 0, 0, 0, 0);
    send_quat(KIND_INV, 0, 0, 0, ONE, 0, 0, 0, 0);
    send_quat(KIND_INV, 0, 0, 0, 0, ONE, 0, 0, 0);
    send_quat(KIND_INV, 1, 0, 0, 0, 0, 0, 0, 0);
    send_quat(KIND_INV, WMAX, WMIN, WMAX, WMIN, 0, 0, 0, 0);
    send_quat(3'd6, WMAX, WMIN, 1, 2, 3, 4, 5, 6);
    send_quat(3'd7, -1, -1, -1, -1, -1, -1, -1, -1);

    // Random items with mixed component scales
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      it.kind = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                             : 3'($urandom_range(0, 5));
      it.a_x = rand_comp(); it.a_y = rand_comp(); it.a_z = rand_comp(); it.a_w = rand_comp();
      it.b_x = rand_comp(); it.b_y = rand_comp(); it.b_z = rand_comp(); it.b_w = rand_comp();
      send_beat(it);
    end
    start <= 1'b0;

    // Drain the pipeline, then hold a little longer
    wait_cycles = 0;
    while (pending_count != 0 && wait_cycles < 10 * DRAIN_CYCLES) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_count != 0)
      $display("mismatch: %0d results never arrived", pending_count);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
